@@ rtl/core/ictf_pkg.sv @@
// shared constants and the cordic angle table for the tilt filter
// no dependencies
`default_nettype none
package ictf_pkg;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned GAIN_W = 24;
  localparam int unsigned ANGLE_W = 25;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd64225;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd128070;
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 25'sd11796480;
  localparam logic signed [ANGLE_W-1:0] RIGHT_ANGLE = 25'sd5898240;
  localparam int unsigned CORDIC_STEPS = 20;
  localparam logic [0:0] REG_ALPHA = 1'b0;
  localparam logic [0:0] REG_GAIN = 1'b1;

  function automatic logic signed [ANGLE_W-1:0] atan_q16(input logic [4:0] i);
    logic signed [ANGLE_W-1:0] v;
    case (i)
      5'd0: v = 25'sd2949120;
      5'd1: v = 25'sd1740967;
      5'd2: v = 25'sd919879;
      5'd3: v = 25'sd466945;
      5'd4: v = 25'sd234379;
      5'd5: v = 25'sd117304;
      5'd6: v = 25'sd58666;
      5'd7: v = 25'sd29335;
      5'd8: v = 25'sd14668;
      5'd9: v = 25'sd7334;
      5'd10: v = 25'sd3667;
      5'd11: v = 25'sd1833;
      5'd12: v = 25'sd917;
      5'd13: v = 25'sd458;
      5'd14: v = 25'sd229;
      5'd15: v = 25'sd115;
      5'd16: v = 25'sd57;
      5'd17: v = 25'sd29;
      5'd18: v = 25'sd14;
      5'd19: v = 25'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

@@ rtl/core/imu_complementary_tilt_filter.sv @@
// roll and pitch complementary tilt filter: square root, cordic atan2 and blend; uses ictf_pkg
// per angle a load, 24 root steps, 20 cordic steps and a clamp; then 7 blend steps per angle,
// skipped when seeding or on a zero step, and an out and a wait state to finish
// in_tready is low while an item is in work, and a result not yet taken holds the next item
// in its last state
// synchronous active-low reset: alpha 64225, gyro gain 128070, angles zero, unseeded
`default_nettype none
module imu_complementary_tilt_filter (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // accel_x[15:0], accel_y[31:16], accel_z[47:32], gyro_x[63:48],
  // gyro_y[79:64], step_time[99:80], zero pad [103:100]
  input  wire logic [103:0]        in_tdata,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // roll_angle[24:0], pitch_angle[49:25], zero pad [55:50]
  output logic [55:0]              out_tdata,
  // was_updated
  output logic                     out_tuser,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [23:0]         cfg_data
);
  import ictf_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_LOAD  = 8'b00000010,
    S_ROOT  = 8'b00000100,
    S_CORD  = 8'b00001000,
    S_CLAMP = 8'b00010000,
    S_MUL   = 8'b00100000,
    S_OUT   = 8'b01000000,
    S_WAIT  = 8'b10000000
  } state_t;

  state_t state_r;
  logic [4:0] cnt_r;
  logic       pass_r;       // 0 roll, 1 pitch
  logic [2:0] mstep_r;

  logic [ALPHA_W-1:0] alpha_r;
  logic [GAIN_W-1:0]  gain_r;
  logic signed [ANGLE_W-1:0] roll_r, pitch_r;
  logic seeded_r;

  logic signed [15:0] ax_r, ay_r, az_r, gx_r, gy_r;
  logic [19:0] dt_r;

  // root: radicand up to 2^47, result 24 bits
  logic [47:0] rem_r;
  logic [47:0] rad_r;
  logic [23:0] root_r;
  // cordic operands
  logic signed [27:0] cx_r, cy_r;
  logic signed [ANGLE_W:0] cz_r;
  logic signed [ANGLE_W-1:0] acc_roll_r, acc_pitch_r;

  // blend
  logic signed [63:0] prod_r;
  logic signed [63:0] acc_r;
  logic signed [32:0] gang_r;

  logic [55:0] out_data_r;
  logic        out_upd_r;
  logic        out_v_r;

  logic signed [15:0] o1, o2, num;
  always_comb begin
    if (!pass_r) begin
      num = ay_r; o1 = ax_r; o2 = az_r;
    end else begin
      num = ax_r; o1 = ay_r; o2 = az_r;
    end
  end

  // one restoring root step consumes two radicand bits
  logic [25:0] trial;
  logic [25:0] rem_sh;
  always_comb begin
    rem_sh = {rem_r[23:0], rad_r[47:46]};
    trial  = {root_r, 2'b01};
  end

  logic signed [27:0] xs, ys;
  always_comb begin
    xs = cx_r >>> cnt_r;
    ys = cy_r >>> cnt_r;
  end

  logic signed [31:0] sq1, sq2;
  always_comb begin
    sq1 = 32'(o1) * 32'(o1);
    sq2 = 32'(o2) * 32'(o2);
  end

  // shared multiplier for blend; rate * gain * dt is split into two halves of the first product
  logic signed [32:0] ma;
  logic signed [24:0] mb;
  logic signed [57:0] mprod;
  always_comb begin
    ma = '0; mb = '0;
    case (mstep_r)
      3'd0: begin ma = 33'(pass_r ? gy_r : gx_r); mb = $signed({1'b0, gain_r}); end
      3'd1: begin ma = 33'($signed({1'b0, prod_r[19:0]})); mb = 25'($signed({1'b0, dt_r})); end
      3'd2: begin ma = 33'($signed(prod_r[39:20])); mb = 25'($signed({1'b0, dt_r})); end
      3'd4: begin ma = gang_r; mb = 25'($signed({1'b0, alpha_r})); end
      3'd5: begin
        ma = 33'(pass_r ? acc_pitch_r : acc_roll_r);
        mb = 25'($signed({1'b0, 17'h10000 - {1'b0, alpha_r}}));
      end
      default: begin ma = '0; mb = '0; end
    endcase
    mprod = ma * mb;
  end

  logic signed [ANGLE_W-1:0] prev_ang;
  assign prev_ang = pass_r ? pitch_r : roll_r;
  logic signed [63:0] rnd;
  assign rnd = (acc_r + 64'sd32768) >>> 16;
  logic signed [ANGLE_W-1:0] sat_v;
  always_comb begin
    if (rnd > 64'(ANGLE_LIMIT)) sat_v = ANGLE_LIMIT;
    else if (rnd < -64'(ANGLE_LIMIT)) sat_v = -ANGLE_LIMIT;
    else sat_v = rnd[ANGLE_W-1:0];
  end

  logic upd;
  assign upd = !seeded_r || (dt_r != 20'd0);

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_upd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      alpha_r <= ALPHA_RESET;
      gain_r <= GAIN_RESET;
      roll_r <= '0;
      pitch_r <= '0;
      seeded_r <= 1'b0;
      out_v_r <= 1'b0;
      cnt_r <= '0;
      pass_r <= 1'b0;
      mstep_r <= '0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
          REG_GAIN:  gain_r <= cfg_data;
          default: ;
        endcase
      end
      if (out_v_r && out_tready && state_r != S_WAIT) out_v_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            ax_r <= in_tdata[15:0];
            ay_r <= in_tdata[31:16];
            az_r <= in_tdata[47:32];
            gx_r <= in_tdata[63:48];
            gy_r <= in_tdata[79:64];
            dt_r <= in_tdata[99:80];
            pass_r <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          rad_r <= {16'(0) + 32'(sq1 + sq2), 16'h0000};
          rem_r <= '0;
          root_r <= '0;
          cnt_r <= '0;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          rad_r <= {rad_r[45:0], 2'b00};
          if (rem_sh >= trial) begin
            rem_r <= 48'(rem_sh - trial);
            root_r <= {root_r[22:0], 1'b1};
          end else begin
            rem_r <= 48'(rem_sh);
            root_r <= {root_r[22:0], 1'b0};
          end
          if (cnt_r == 5'd23) begin
            cnt_r <= '0;
            state_r <= S_CORD;
          end else cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'd23) begin
            cx_r <= 28'($signed({1'b0, root_r[22:0],
                     (rem_sh >= trial) ? 1'b1 : 1'b0}));
            cy_r <= 28'(num) <<< 8;
            cz_r <= '0;
          end
        end
        S_CORD: begin
          if (cy_r >= 0) begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + 26'(atan_q16(cnt_r));
          end else begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - 26'(atan_q16(cnt_r));
          end
          if (cnt_r == 5'(CORDIC_STEPS - 1)) begin
            cnt_r <= '0;
            state_r <= S_CLAMP;
          end else cnt_r <= cnt_r + 5'd1;
        end
        S_CLAMP: begin
          logic signed [ANGLE_W-1:0] z;
          if (num == 16'sd0 && o1 == 16'sd0 && o2 == 16'sd0) z = '0;
          else if (cz_r > 26'(RIGHT_ANGLE)) z = RIGHT_ANGLE;
          else if (cz_r < -26'(RIGHT_ANGLE)) z = -RIGHT_ANGLE;
          else z = cz_r[ANGLE_W-1:0];
          if (!pass_r) begin
            acc_roll_r <= z;
            pass_r <= 1'b1;
            state_r <= S_LOAD;
          end else begin
            acc_pitch_r <= z;
            pass_r <= 1'b0;
            mstep_r <= '0;
            state_r <= seeded_r && upd ? S_MUL : S_OUT;
          end
        end
        S_MUL: begin
          case (mstep_r)
            3'd0: prod_r <= 64'(mprod);
            3'd1: acc_r <= 64'(mprod);
            3'd2: acc_r <= acc_r + (64'(mprod) <<< 20);
            3'd3: gang_r <= 33'(prev_ang) + 33'((acc_r + 64'sd134217728) >>> 28);
            3'd4: acc_r <= 64'(mprod);
            3'd5: acc_r <= acc_r + 64'(mprod);
            default: begin
              if (!pass_r) roll_r <= sat_v; else pitch_r <= sat_v;
            end
          endcase
          if (mstep_r == 3'd6) begin
            mstep_r <= '0;
            if (!pass_r) pass_r <= 1'b1;
            else state_r <= S_OUT;
          end else mstep_r <= mstep_r + 3'd1;
        end
        S_OUT: begin
          if (!seeded_r) begin
            roll_r <= acc_roll_r;
            pitch_r <= acc_pitch_r;
          end
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (!out_v_r || out_tready) begin
            out_data_r <= {6'd0, pitch_r, roll_r};
            out_upd_r <= upd;
            out_v_r <= 1'b1;
            seeded_r <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ tb/sv/tilt_filter_checker.sv @@
// checker for the tilt filter: watches the input, result and register channels
// predicts roll, pitch and the update flag; depends on ictf_pkg
`timescale 1ns / 100ps
module tilt_filter_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [103:0] in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [55:0]  out_tdata,
  input  wire logic         out_tuser,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic         cfg_index,
  input  wire logic [23:0]  cfg_data,
  output int                fail_count,
  output int                pending_count
);
  import ictf_pkg::*;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] roll;
    logic signed [ANGLE_W-1:0] pitch;
    logic                      updated;
  } angles_t;

  angles_t expected_angles[$];
  longint  alpha_q16;
  longint  gain_q24;
  longint  roll_q16;
  longint  pitch_q16;
  bit      seeded;

  localparam longint TAN_TABLE[20] = '{2949120, 1740967, 919879, 466945, 234379,
    117304, 58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

  function automatic longint int_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  // atan2(num, sqrt(o1^2 + o2^2)) in q9.16 degrees
  function automatic longint tilt_q16(longint num, longint o1, longint o2);
    longint x;
    longint y;
    longint z;
    longint xs;
    longint ys;
    x = int_root(longint'(o1 * o1 + o2 * o2) << 16);
    y = num * 256;
    z = 0;
    if (x == 0 && y == 0) return 0;
    for (int i = 0; i < 20; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + TAN_TABLE[i];
      end else begin
        x = x - ys; y = y + xs; z = z - TAN_TABLE[i];
      end
    end
    if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
    if (z < -RIGHT_ANGLE) z = -RIGHT_ANGLE;
    return z;
  endfunction

  function automatic longint fuse_angle(longint prev, longint rate, longint dt, longint acc);
    longint inc;
    longint mix;
    inc = (rate * gain_q24 * dt + (64'sd1 <<< 27)) >>> 28;
    mix = alpha_q16 * (prev + inc) + (65536 - alpha_q16) * acc;
    mix = (mix + 32768) >>> 16;
    if (mix > ANGLE_LIMIT) mix = ANGLE_LIMIT;
    if (mix < -ANGLE_LIMIT) mix = -ANGLE_LIMIT;
    return mix;
  endfunction

  function automatic angles_t next_angles(logic [103:0] d);
    longint ax;
    longint ay;
    longint az;
    longint dt;
    longint acc_roll;
    longint acc_pitch;
    angles_t r;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    dt = longint'(d[99:80]);
    acc_roll = tilt_q16(ay, ax, az);
    acc_pitch = tilt_q16(ax, ay, az);
    r.updated = 1'b1;
    if (!seeded) begin
      roll_q16 = acc_roll;
      pitch_q16 = acc_pitch;
      seeded = 1'b1;
    end else if (dt != 0) begin
      roll_q16 = fuse_angle(roll_q16, longint'($signed(d[63:48])), dt, acc_roll);
      pitch_q16 = fuse_angle(pitch_q16, longint'($signed(d[79:64])), dt, acc_pitch);
    end else begin
      r.updated = 1'b0;
    end
    r.roll = roll_q16[ANGLE_W-1:0];
    r.pitch = pitch_q16[ANGLE_W-1:0];
    return r;
  endfunction

  assign pending_count = expected_angles.size();

  always @(posedge clk) begin
    angles_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      alpha_q16 <= ALPHA_RESET;
      gain_q24 <= GAIN_RESET;
      roll_q16 = 0;
      pitch_q16 = 0;
      seeded = 1'b0;
      expected_angles.delete();
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ALPHA) alpha_q16 <= cfg_data[15:0];
        else gain_q24 <= cfg_data;
      end
      if (in_tvalid && in_tready) expected_angles.push_back(next_angles(in_tdata));
      if (out_tvalid && out_tready) begin
        if (expected_angles.size() == 0) begin
          $error("unexpected result item roll %0d", $signed(out_tdata[24:0]));
          errs = errs + 1;
        end else begin
          e = expected_angles.pop_front();
          if (out_tdata[24:0] !== e.roll) begin
            $error("roll_angle expected %0d actual %0d", e.roll, $signed(out_tdata[24:0]));
            errs = errs + 1;
          end
          if (out_tdata[49:25] !== e.pitch) begin
            $error("pitch_angle expected %0d actual %0d", e.pitch, $signed(out_tdata[49:25]));
            errs = errs + 1;
          end
          if (out_tuser !== e.updated) begin
            $error("was_updated expected %0d actual %0d", e.updated, out_tuser);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// top of the tilt filter testbench: clock, reset, stimulus and verdict
// depends on ictf_pkg, imu_complementary_tilt_filter and tilt_filter_checker
`timescale 1ns / 100ps
module testbench;
  import ictf_pkg::*;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [103:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready;
  logic [55:0]  out_tdata;
  logic         out_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic         cfg_index;
  logic [23:0]  cfg_data;
  int           fail_count;
  int           pending_count;
  int           send_idle_pct;
  int           stall_pct;
  int           hold_off_cycles;
  int           quiet_cycles;

  imu_complementary_tilt_filter DUT (.*);
  tilt_filter_checker checker_u (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // receiver: random stalls plus an optional long hold-off
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_valid && cfg_ready)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("imu_complementary_tilt_filter verification failed");
      $finish;
    end
  end

  task automatic write_reg(input logic idx, input logic [23:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // in_tvalid stays high after acceptance until the next item, an idle gap or drain
  task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy,
                             input logic [19:0] dt);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'd0, dt, gy, gx, az, ay, ax};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  function automatic logic [15:0] edge_word;
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic random_samples(input int n);
    logic [19:0] dt;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: dt = 20'd0;
        1: dt = 20'($urandom);
        default: dt = 20'($urandom_range(2000, 1));
      endcase
      if ($urandom_range(9) == 0)
        send_sample(edge_word(), edge_word(), edge_word(), edge_word(), edge_word(), dt);
      else
        // mostly realistic gravity vectors with moderate rates
        send_sample(16'($urandom_range(33000) - 16500), 16'($urandom_range(33000) - 16500),
                    16'($urandom_range(33000) - 16500), 16'($urandom_range(8000) - 4000),
                    16'($urandom_range(8000) - 4000), dt);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_ALPHA;
    cfg_data = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    hold_off_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: zero vector seeds, then extremes and a skipped step
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd100, -16'sd100, 20'd0);
    send_sample(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 20'hfffff);
    send_sample(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, 20'hfffff);
    send_sample(16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 20'd1);
    send_sample(16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd1024);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd131, 16'sd131, 20'd1048);
    send_sample(-16'sd1, -16'sd1, -16'sd1, -16'sd1, -16'sd1, 20'd0);
    send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 20'hfffff);
    drain();

    write_reg(REG_GAIN, 24'hffffff);
    write_reg(REG_ALPHA, 24'h00ffff);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 20'hfffff);
    send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd32767, -16'sd32768, 20'hfffff);
    send_sample(16'sd0, 16'sd0, 16'sd16384, -16'sd32768, 16'sd32767, 20'hfffff);
    drain();
    write_reg(REG_ALPHA, 24'd0);
    write_reg(REG_GAIN, 24'd0);
    send_sample(16'sd300, -16'sd9000, 16'sd12000, 16'sd500, 16'sd500, 20'd50);
    drain();

    write_reg(REG_ALPHA, 24'(ALPHA_RESET));
    write_reg(REG_GAIN, GAIN_RESET);
    random_samples(300);
    drain();

    write_reg(REG_ALPHA, 24'($urandom));
    write_reg(REG_GAIN, 24'($urandom));
    send_idle_pct = 46;
    random_samples(300);
    drain();

    // long hold-off while the sender keeps offering items
    send_idle_pct = 0;
    stall_pct = 46;
    @(negedge clk);
    hold_off_cycles <= 800;
    random_samples(300);
    drain();

    write_reg(REG_ALPHA, 24'h00ffff);
    write_reg(REG_GAIN, 24'hffffff);
    send_idle_pct = 27;
    stall_pct = 27;
    random_samples(330);
    stall_pct = 0;
    drain();

    if (fail_count == 0)
      $display("imu_complementary_tilt_filter verification clean");
    else
      $display("imu_complementary_tilt_filter verification failed");
    $finish;
  end
endmodule
